>>> src/co2_sensor_uart_frame_engine_assert.svh
// Assertion macros for the sensor frame engine.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef CO2_SENSOR_UART_FRAME_ENGINE_ASSERT_SVH
`define CO2_SENSOR_UART_FRAME_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define CSE_ASSERT_IMPL(lbl, ante, cons, msg)
`define CSE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/cse_pkg.sv
package cse_pkg;

    localparam int FRAME_BYTES = 9;

    localparam logic [7:0] FRAME_START = 8'hFF;
    localparam logic [7:0] FRAME_ADDR  = 8'h01;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] RANGE_2000    = 16'd2000;
    localparam logic [15:0] RANGE_5000    = 16'd5000;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_RX_BYTE = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_CHECKSUM = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_RESULT = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        last;
        status_t     status;
        logic [15:0] co2_ppm;
        logic [15:0] range_ppm;
        logic        range_valid;
        logic        auto_cal_on;
        logic [31:0] version_ascii;
    } result_t;

endpackage

>>> src/cse_ifs.sv
interface cse_req_if import cse_pkg::*;
(
);
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] command_byte;
    logic [7:0] arg_byte3;
    logic [7:0] arg_byte4;
    logic [7:0] arg_byte5;
    logic [7:0] arg_byte6;
    logic [7:0] arg_byte7;
    logic [7:0] rx_byte;

    modport source
    (
        output valid, cmd, command_byte, arg_byte3, arg_byte4, arg_byte5,
               arg_byte6, arg_byte7, rx_byte,
        input  ready
    );
    modport sink
    (
        input  valid, cmd, command_byte, arg_byte3, arg_byte4, arg_byte5,
               arg_byte6, arg_byte7, rx_byte,
        output ready
    );
endinterface

interface cse_rsp_if import cse_pkg::*;
(
);
    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        last;
    status_t     status;
    logic [15:0] co2_ppm;
    logic [15:0] range_ppm;
    logic        range_valid;
    logic        auto_cal_on;
    logic [31:0] version_ascii;

    modport source
    (
        output valid, kind, tx_byte, last, status, co2_ppm, range_ppm,
               range_valid, auto_cal_on, version_ascii,
        input  ready
    );
    modport sink
    (
        input  valid, kind, tx_byte, last, status, co2_ppm, range_ppm,
               range_valid, auto_cal_on, version_ascii,
        output ready
    );
endinterface

interface cse_cfg_if import cse_pkg::*;
(
);
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source
    (
        output valid, data,
        input  ready
    );
    modport sink
    (
        input  valid, data,
        output ready
    );
endinterface

>>> src/co2_sensor_uart_frame_engine.sv
// Frame engine for a 9-byte sensor link. Each beat on req is a send, a received
// byte or a time tick. For received bytes and ticks, a result, when there is one,
// sits in the output register the cycle after the beat, and req stays ready while
// that register is drained or empty and no send is running, so one item per cycle
// flows. A send produces nine transmit beats (FF, 01, command, five arguments,
// checksum, with last on the checksum) from a small frame buffer, one per rsp
// beat; req is held off until the checksum byte is in the output register. The
// response window is armed by the send and closes on the ninth received byte or
// when the tick count reaches the timeout value written on cfg (reset 1000).
`include "co2_sensor_uart_frame_engine_assert.svh"

module co2_sensor_uart_frame_engine import cse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cse_req_if.sink      req,
    cse_rsp_if.source    rsp,
    cse_cfg_if.sink      cfg
);

    localparam int RX_STORED = FRAME_BYTES - 1;
    localparam int TX_STORED = FRAME_BYTES - 1;

    logic [15:0] timeout_reg;
    logic        waiting_reg,    waiting_next;
    logic [3:0]  rx_count_reg,   rx_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  sent_cmd_reg,   sent_cmd_next;
    logic        tx_busy_reg,    tx_busy_next;
    logic [2:0]  tx_idx_reg,     tx_idx_next;
    logic        out_valid_reg,  out_valid_next;
    result_t     res_reg,        res_next;

    // frame bytes 1..8 of the current send, and response bytes 0..7
    logic [7:0]  tx_buf_reg [TX_STORED];
    logic [7:0]  rx_store   [RX_STORED];

    logic        out_free;
    logic        in_accept;
    logic        rx_wr;
    logic        tx_load;
    logic [7:0]  tx_sum;
    logic [7:0]  rx_sum;
    logic [15:0] tick_inc;
    logic [15:0] range_val;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !tx_busy_reg && out_free;
    assign in_accept = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign tx_sum = 8'(FRAME_ADDR + req.command_byte + req.arg_byte3 + req.arg_byte4
                       + req.arg_byte5 + req.arg_byte6 + req.arg_byte7);
    assign rx_sum = 8'(rx_store[1] + rx_store[2] + rx_store[3] + rx_store[4]
                       + rx_store[5] + rx_store[6] + rx_store[7]);
    assign tick_inc  = (tick_count_reg == 16'hFFFF) ? tick_count_reg
                                                    : 16'(tick_count_reg + 16'd1);
    assign range_val = {rx_store[4], rx_store[5]};

    always_comb
    begin
        waiting_next    = waiting_reg;
        rx_count_next   = rx_count_reg;
        tick_count_next = tick_count_reg;
        sent_cmd_next   = sent_cmd_reg;
        tx_busy_next    = tx_busy_reg;
        tx_idx_next     = tx_idx_reg;
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;
        rx_wr           = 1'b0;
        tx_load         = 1'b0;

        if (out_free)
        begin
            out_valid_next = 1'b0;
        end

        if (tx_busy_reg && out_free)
        begin
            out_valid_next   = 1'b1;
            res_next         = '0;
            res_next.kind    = KIND_TX;
            res_next.tx_byte = tx_buf_reg[tx_idx_reg];
            res_next.last    = (tx_idx_reg == 3'(TX_STORED - 1));
            tx_idx_next      = 3'(tx_idx_reg + 3'd1);
            if (res_next.last)
            begin
                tx_busy_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            case (req.cmd)
                CMD_SEND:
                begin
                    out_valid_next   = 1'b1;
                    res_next         = '0;
                    res_next.kind    = KIND_TX;
                    res_next.tx_byte = FRAME_START;
                    tx_load          = 1'b1;
                    tx_busy_next     = 1'b1;
                    tx_idx_next      = '0;
                    waiting_next     = 1'b1;
                    rx_count_next    = '0;
                    tick_count_next  = '0;
                    sent_cmd_next    = req.command_byte;
                end
                CMD_RX_BYTE:
                begin
                    if (waiting_reg)
                    begin
                        if (rx_count_reg == 4'(FRAME_BYTES - 1))
                        begin
                            // ninth byte is the checksum, taken straight from the beat
                            waiting_next   = 1'b0;
                            rx_count_next  = '0;
                            out_valid_next = 1'b1;
                            res_next       = '0;
                            res_next.kind  = KIND_RESULT;
                            if (8'(rx_sum + req.rx_byte) != 8'h00)
                            begin
                                res_next.status = ST_CHECKSUM;
                            end
                            else if (rx_store[0] != FRAME_START || rx_store[1] != sent_cmd_reg)
                            begin
                                res_next.status = ST_MISMATCH;
                            end
                            else
                            begin
                                res_next.status        = ST_OK;
                                res_next.co2_ppm       = {rx_store[2], rx_store[3]};
                                res_next.range_ppm     = range_val;
                                res_next.range_valid   = (range_val == RANGE_2000)
                                                      || (range_val == RANGE_5000);
                                res_next.auto_cal_on   = rx_store[7][0];
                                res_next.version_ascii = {rx_store[2], rx_store[3],
                                                          rx_store[4], rx_store[5]};
                            end
                        end
                        else
                        begin
                            rx_wr         = 1'b1;
                            rx_count_next = 4'(rx_count_reg + 4'd1);
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (waiting_reg)
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= timeout_reg)
                        begin
                            waiting_next    = 1'b0;
                            rx_count_next   = '0;
                            out_valid_next  = 1'b1;
                            res_next        = '0;
                            res_next.kind   = KIND_RESULT;
                            res_next.status = ST_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            waiting_reg    <= 1'b0;
            rx_count_reg   <= '0;
            tick_count_reg <= '0;
            sent_cmd_reg   <= '0;
            tx_busy_reg    <= 1'b0;
            tx_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.data;
            end
            waiting_reg    <= waiting_next;
            rx_count_reg   <= rx_count_next;
            tick_count_reg <= tick_count_next;
            sent_cmd_reg   <= sent_cmd_next;
            tx_busy_reg    <= tx_busy_next;
            tx_idx_reg     <= tx_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (tx_load)
        begin
            tx_buf_reg[0] <= FRAME_ADDR;
            tx_buf_reg[1] <= req.command_byte;
            tx_buf_reg[2] <= req.arg_byte3;
            tx_buf_reg[3] <= req.arg_byte4;
            tx_buf_reg[4] <= req.arg_byte5;
            tx_buf_reg[5] <= req.arg_byte6;
            tx_buf_reg[6] <= req.arg_byte7;
            tx_buf_reg[7] <= 8'(8'h00 - tx_sum);
        end
        if (rx_wr)
        begin
            rx_store[rx_count_reg[2:0]] <= req.rx_byte;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = res_reg.kind;
    assign rsp.tx_byte       = res_reg.tx_byte;
    assign rsp.last          = res_reg.last;
    assign rsp.status        = res_reg.status;
    assign rsp.co2_ppm       = res_reg.co2_ppm;
    assign rsp.range_ppm     = res_reg.range_ppm;
    assign rsp.range_valid   = res_reg.range_valid;
    assign rsp.auto_cal_on   = res_reg.auto_cal_on;
    assign rsp.version_ascii = res_reg.version_ascii;

    `CSE_ASSERT_NEVER(a_tx_run_gap, out_valid_reg && res_reg.kind == KIND_TX && !res_reg.last && !tx_busy_reg, "transmit run ended before checksum beat")
    `CSE_ASSERT_IMPL(a_idle_count, !waiting_reg, rx_count_reg == 4'd0, "receive count not cleared when idle")
    `CSE_ASSERT_NEVER(a_count_range, rx_count_reg > 4'(FRAME_BYTES - 1), "receive count past frame")
    `CSE_ASSERT_IMPL(a_err_zero, out_valid_reg && res_reg.kind == KIND_RESULT && res_reg.status != ST_OK, res_reg.co2_ppm == 16'd0 && res_reg.range_ppm == 16'd0 && !res_reg.range_valid && !res_reg.auto_cal_on && res_reg.version_ascii == 32'd0, "error result carries data")

endmodule
